@@ design/olt_pkg.sv @@
// ----------------------------------------------------------------------------
// olt_pkg
// Shared widths, command and status codes, and the cell control types for
// the ordered list table.
// ----------------------------------------------------------------------------
package olt_pkg;

	localparam int DEPTH = 32;
	localparam int LEN_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int POS_W = 6;
	localparam int VAL_W = 32;
	localparam int CMD_W = 3;
	localparam int ST_W  = 3;
	localparam int ANS_W = 7;
	localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

	localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DEL   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FIND  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_COUNT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LIST  = 3'd4;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_INVALID  = 3'd1;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_SHIFT,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [VAL_W-1:0]   key;
	} cell_ctl_t;

endpackage

@@ design/olt_cell.sv @@
// ----------------------------------------------------------------------------
// olt_cell
// One list entry: holds its value, compares it against the broadcast key,
// and takes its right neighbor's value on a delete shift or list rotation.
// ----------------------------------------------------------------------------
module olt_cell import olt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic             wr,
	input  logic             occ,
	input  logic             tail,
	input  logic             hit_in,
	input  logic [VAL_W-1:0] next_val,
	input  logic [VAL_W-1:0] head_val,
	output logic [VAL_W-1:0] entry,
	output logic             match,
	output logic             hit_out,
	output logic             first
);

	logic [VAL_W-1:0] entry_q;
	logic             match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else begin
			match_q <= occ && (entry_q == ctl.key);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q <= ctl.key;
		end else begin
			case (ctl.op)
				CELL_SHIFT: begin
					// this cell is at or past the first match: close the gap
					if (hit_out)
						entry_q <= next_val;
				end
				CELL_ROTATE: begin
					entry_q <= tail ? head_val : next_val;
				end
				default: ;
			endcase
		end
	end

	assign entry   = entry_q;
	assign match   = match_q;
	assign hit_out = hit_in | match_q;
	assign first   = match_q & ~hit_in;

endmodule

@@ design/ordered_list_table_unit.sv @@
// ----------------------------------------------------------------------------
// ordered_list_table_unit
// Ordered list of signed values kept in a row of compare/shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction (cmd, position, value) is taken at a rising edge
//   with start high and busy low. Results come out on status, answer,
//   item_value and last, each valid for exactly one cycle while valid is high.
//   The receiver cannot stall; every result is taken in its cycle.
// Timing:
//   Cycle after accept: all cells compare against the key in parallel and
//   register their match flags. Next cycle: first-match, match count and the
//   add/delete update are resolved, and the single result is registered.
//   busy is low in that execute cycle, so add, delete, find and count can
//   take a new command while the previous one resolves.
//   List rotates the cell row once per entry and emits one entry per cycle
//   from the head cell, staying busy throughout; it emits length results,
//   last set on the final one. An empty list gives one result like the
//   other commands. The row is back in order after length rotations.
//   Command codes 5 to 7 are accepted and give no result.
// Reset:
//   arst_n clears length to zero and returns to idle; entry storage is not
//   cleared, only entries below length are ever read.
// ----------------------------------------------------------------------------
module ordered_list_table_unit import olt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [CMD_W-1:0]        cmd,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	output logic                    valid,
	output logic [ST_W-1:0]         status,
	output logic signed [ANS_W-1:0] answer,
	output logic signed [VAL_W-1:0] item_value,
	output logic                    last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_EXEC,
		S_LIST
	} state_t;

	state_t           state_q;
	logic [CMD_W-1:0] cmd_q;
	logic [POS_W-1:0] pos_q;
	logic [VAL_W-1:0] key_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] cnt_q;
	logic             valid_q;
	logic [ST_W-1:0]  status_q;
	logic [ANS_W-1:0] answer_q;
	logic [VAL_W-1:0] item_q;
	logic             last_q;

	cell_ctl_t        ctl;
	logic [DEPTH-1:0] wr;
	logic [DEPTH-1:0] occ;
	logic [DEPTH-1:0] tail;
	logic [DEPTH-1:0] match;
	logic [DEPTH-1:0] first;
	logic [DEPTH:0]   hit;
	logic [VAL_W-1:0] entry [DEPTH];

	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] len_ext;
	logic [IDX_W-1:0] first_idx;
	logic [LEN_W-1:0] match_cnt;
	logic             add_wr;
	logic             to_list;
	logic             accept;
	logic             list_end;

	logic             res_v;
	logic [ST_W-1:0]  res_st;
	logic [ANS_W-1:0] res_ans;
	logic [LEN_W-1:0] len_d;

	assign pos_ext   = CMP_W'(pos_q);
	assign len_ext   = CMP_W'(len_q);
	assign match_cnt = LEN_W'($countones(match));
	assign list_end  = (LEN_W'(cnt_q + 1'b1) == len_q);
	assign hit[0]    = 1'b0;

	always_comb begin
		first_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first[i])
				first_idx = first_idx | IDX_W'(i);
		end
	end

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic [VAL_W-1:0] nbr;

			assign wr[g]   = add_wr && (pos_ext == CMP_W'(g));
			assign occ[g]  = (LEN_W'(g) < len_q);
			assign tail[g] = (LEN_W'(g + 1) == len_q);
			assign nbr     = (g == DEPTH - 1) ? entry[g] : entry[(g + 1) % DEPTH];

			olt_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.wr       (wr[g]),
				.occ      (occ[g]),
				.tail     (tail[g]),
				.hit_in   (hit[g]),
				.next_val (nbr),
				.head_val (entry[0]),
				.entry    (entry[g]),
				.match    (match[g]),
				.hit_out  (hit[g+1]),
				.first    (first[g])
			);
		end
	endgenerate

	// command resolution in the execute cycle, and row rotation while listing
	always_comb begin
		ctl.op  = CELL_HOLD;
		ctl.key = key_q;
		add_wr  = 1'b0;
		to_list = 1'b0;
		res_v   = 1'b0;
		res_st  = ST_OK;
		res_ans = '0;
		len_d   = len_q;
		if (state_q == S_LIST) begin
			ctl.op = CELL_ROTATE;
		end else if (state_q == S_EXEC) begin
			case (cmd_q)
				CMD_ADD: begin
					res_v = 1'b1;
					if (pos_ext > len_ext) begin
						res_st = ST_INVALID;
					end else if (pos_ext == len_ext && len_q == LEN_W'(DEPTH)) begin
						res_st = ST_FULL;
					end else begin
						add_wr = 1'b1;
						if (pos_ext == len_ext)
							len_d = LEN_W'(len_q + 1'b1);
					end
				end
				CMD_DEL: begin
					res_v = 1'b1;
					if (len_q == '0) begin
						res_st = ST_EMPTY;
					end else if (match == '0) begin
						res_st = ST_NOTFOUND;
					end else begin
						ctl.op = CELL_SHIFT;
						len_d  = LEN_W'(len_q - 1'b1);
					end
				end
				CMD_FIND: begin
					res_v   = 1'b1;
					res_ans = (match != '0) ? ANS_W'(first_idx) : '1;
				end
				CMD_COUNT: begin
					res_v   = 1'b1;
					res_ans = ANS_W'(match_cnt);
				end
				CMD_LIST: begin
					if (len_q == '0) begin
						res_v  = 1'b1;
						res_st = ST_EMPTY;
					end else begin
						to_list = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign busy   = (state_q == S_CMP) || (state_q == S_LIST) || to_list;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cmd_q    <= '0;
			pos_q    <= '0;
			key_q    <= '0;
			len_q    <= '0;
			cnt_q    <= '0;
			valid_q  <= 1'b0;
			status_q <= ST_OK;
			answer_q <= '0;
			item_q   <= '0;
			last_q   <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				S_IDLE: ;
				S_CMP: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					len_q    <= len_d;
					cnt_q    <= '0;
					valid_q  <= res_v;
					status_q <= res_st;
					answer_q <= res_ans;
					item_q   <= '0;
					last_q   <= 1'b1;
					state_q  <= to_list ? S_LIST : S_IDLE;
				end
				S_LIST: begin
					valid_q  <= 1'b1;
					status_q <= ST_OK;
					answer_q <= '0;
					item_q   <= entry[0];
					last_q   <= list_end;
					cnt_q    <= LEN_W'(cnt_q + 1'b1);
					if (list_end)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (accept) begin
				cmd_q   <= cmd;
				pos_q   <= position;
				key_q   <= value;
				state_q <= S_CMP;
			end
		end
	end

	assign valid      = valid_q;
	assign status     = status_q;
	assign answer     = answer_q;
	assign item_value = item_q;
	assign last       = last_q;

endmodule

@@ tb/tb_ordered_list_table_unit.sv @@
// ----------------------------------------------------------------------------
// tb_ordered_list_table_unit
// Self-checking bench for the ordered list table. Commands go in over the
// start/busy handshake and a shadow copy of the table predicts every result.
// The checker compares each strobed result field by field, in order.
// Directed cases cover the empty and full table and every command. Random
// traffic then grows, shrinks and searches the table with random idle gaps until its last third.
// ----------------------------------------------------------------------------
module tb_ordered_list_table_unit;
	import olt_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = DEPTH + 8;
	localparam int MAX_PRINTS     = 40;

	typedef struct {
		logic [ST_W-1:0]         status;
		logic signed [ANS_W-1:0] answer;
		logic signed [VAL_W-1:0] item_value;
		logic                    last;
	} list_result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [CMD_W-1:0]        cmd;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] value;
	logic                    valid;
	logic [ST_W-1:0]         status;
	logic signed [ANS_W-1:0] answer;
	logic signed [VAL_W-1:0] item_value;
	logic                    last;

	// shadow of the table
	logic signed [VAL_W-1:0] shadow_entries[DEPTH];
	int                      shadow_len;

	list_result_t pending_results[$];
	list_result_t want_r;

	logic gaps_on;
	int   error_count;
	int   result_count;
	int   idle_cycles;
	int   op_count[5];
	int   ignored_count;
	int   max_len_seen;
	int   full_hits;

	ordered_list_table_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.position  (position),
		.value     (value),
		.valid     (valid),
		.status    (status),
		.answer    (answer),
		.item_value(item_value),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void push_result(logic [ST_W-1:0] st, int ans,
	                                    logic signed [VAL_W-1:0] iv, logic lst);
		list_result_t r;
		r.status     = st;
		r.answer     = ANS_W'(ans);
		r.item_value = iv;
		r.last       = lst;
		pending_results.push_back(r);
	endfunction

	// Updates the shadow table and queues the results one command produces.
	function automatic void apply_command(logic [CMD_W-1:0] c, logic [POS_W-1:0] p,
	                                      logic signed [VAL_W-1:0] v);
		int where;
		int hits;
		if (c <= CMD_LIST)
			op_count[c]++;
		else
			ignored_count++;
		case (c)
			CMD_ADD: begin
				if (int'(p) > shadow_len) begin
					push_result(ST_INVALID, 0, '0, 1'b1);
				end else if (int'(p) == shadow_len) begin
					if (shadow_len >= DEPTH) begin
						full_hits++;
						push_result(ST_FULL, 0, '0, 1'b1);
					end else begin
						shadow_entries[shadow_len] = v;
						shadow_len++;
						push_result(ST_OK, 0, '0, 1'b1);
					end
				end else begin
					shadow_entries[p] = v;
					push_result(ST_OK, 0, '0, 1'b1);
				end
			end
			CMD_DEL: begin
				where = -1;
				for (int i = 0; i < shadow_len; i++)
					if (where < 0 && shadow_entries[i] == v)
						where = i;
				if (shadow_len == 0) begin
					push_result(ST_EMPTY, 0, '0, 1'b1);
				end else if (where < 0) begin
					push_result(ST_NOTFOUND, 0, '0, 1'b1);
				end else begin
					for (int i = where; i + 1 < shadow_len; i++)
						shadow_entries[i] = shadow_entries[i + 1];
					shadow_len--;
					push_result(ST_OK, 0, '0, 1'b1);
				end
			end
			CMD_FIND: begin
				where = -1;
				for (int i = 0; i < shadow_len; i++)
					if (where < 0 && shadow_entries[i] == v)
						where = i;
				push_result(ST_OK, where, '0, 1'b1);
			end
			CMD_COUNT: begin
				hits = 0;
				for (int i = 0; i < shadow_len; i++)
					if (shadow_entries[i] == v)
						hits++;
				push_result(ST_OK, hits, '0, 1'b1);
			end
			CMD_LIST: begin
				if (shadow_len == 0)
					push_result(ST_EMPTY, 0, '0, 1'b1);
				for (int i = 0; i < shadow_len; i++)
					push_result(ST_OK, 0, shadow_entries[i], i + 1 == shadow_len);
			end
			default: ;
		endcase
		if (shadow_len > max_len_seen)
			max_len_seen = shadow_len;
	endfunction

	// Mostly values already in the table or a few corner values, so
	// searches and deletes hit often.
	function automatic logic signed [VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (shadow_len > 0 && r < 45)
			return shadow_entries[$urandom_range(0, shadow_len - 1)];
		if (r < 55)
			return 32'sh8000_0000;
		if (r < 62)
			return 32'sh7FFF_FFFF;
		if (r < 68)
			return '0;
		if (r < 74)
			return -32'sd1;
		if (r < 85)
			return VAL_W'($urandom_range(0, 7));
		return VAL_W'($urandom);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
	                               input logic [63:0] want);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("MISMATCH result %0d %s: got %0h expected %0h", result_count, what,
			         got, want);
	endtask

	// One transaction; returns at the falling edge after acceptance, or after a random idle gap.
	task automatic send_command(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
	                            input logic signed [VAL_W-1:0] v);
		start    <= 1'b1;
		cmd      <= c;
		position <= p;
		value    <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		apply_command(c, p, v);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7))
				@(negedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && valid) begin
			if (pending_results.size() == 0) begin
				report_mismatch("with nothing pending", {61'd0, status}, '0);
			end else begin
				want_r = pending_results.pop_front();
				if (status !== want_r.status)
					report_mismatch("status", 64'(status), 64'(want_r.status));
				if (answer !== want_r.answer)
					report_mismatch("answer", 64'(answer), 64'(want_r.answer));
				if (item_value !== want_r.item_value)
					report_mismatch("item_value", 64'(item_value), 64'(want_r.item_value));
				if (last !== want_r.last)
					report_mismatch("last", 64'(last), 64'(want_r.last));
			end
			result_count++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results pending",
			         idle_cycles, pending_results.size());
			$display("tb_ordered_list_table_unit: FAIL");
			$finish;
		end
	end

	task automatic test_empty_table();
		send_command(CMD_LIST, '0, '0);
		send_command(CMD_DEL, '0, 32'sd5);
		send_command(CMD_FIND, '0, 32'sd5);
		send_command(CMD_COUNT, '0, 32'sd5);
		send_command(CMD_ADD, 6'd1, 32'sd9);
		send_command(CMD_ADD, 6'd63, 32'sd9);
	endtask

	task automatic test_add_and_overwrite();
		send_command(CMD_ADD, 6'd0, 32'sh8000_0000);
		send_command(CMD_ADD, 6'd1, 32'sh7FFF_FFFF);
		send_command(CMD_ADD, 6'd2, '0);
		send_command(CMD_ADD, 6'd3, -32'sd1);
		send_command(CMD_ADD, 6'd4, 32'sh7FFF_FFFF);
		send_command(CMD_ADD, 6'd2, 32'sd5);
		send_command(CMD_ADD, 6'd6, 32'sd5);
	endtask

	task automatic test_search();
		send_command(CMD_FIND, '0, 32'sh7FFF_FFFF);
		send_command(CMD_COUNT, '0, 32'sh7FFF_FFFF);
		send_command(CMD_FIND, '0, 32'sd1234);
		send_command(CMD_COUNT, '0, 32'sd1234);
	endtask

	task automatic test_delete();
		send_command(CMD_DEL, '0, 32'sd1234);
		send_command(CMD_DEL, '0, 32'sh7FFF_FFFF);
		send_command(CMD_DEL, '0, 32'sh8000_0000);
	endtask

	task automatic test_list_and_unused();
		send_command(CMD_LIST, 6'h3F, 32'sh5A5A_A5A5);
		for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
			send_command(CMD_UNUSED_LO + CMD_W'(c - CMD_UNUSED_LO), 6'h3F, -32'sd1);
	endtask

	// Fill to capacity, probe the full table, then empty it again.
	task automatic test_fill_and_drain();
		while (shadow_len < DEPTH)
			send_command(CMD_ADD, POS_W'(shadow_len), pick_value());
		send_command(CMD_ADD, POS_W'(DEPTH), pick_value());
		send_command(CMD_ADD, POS_W'(DEPTH + 1), pick_value());
		send_command(CMD_ADD, POS_W'(DEPTH - 1), 32'sh7FFF_FFFF);
		send_command(CMD_LIST, '0, '0);
		send_command(CMD_FIND, '0, shadow_entries[DEPTH - 1]);
		send_command(CMD_COUNT, '0, shadow_entries[0]);
		while (shadow_len > 0) begin
			if ($urandom_range(0, 9) == 0)
				send_command(CMD_DEL, '0, VAL_W'($urandom));
			else
				send_command(CMD_DEL, '0, shadow_entries[$urandom_range(0, shadow_len - 1)]);
		end
		send_command(CMD_LIST, '0, '0);
	endtask

	// Phases of growth, shrinkage and mixed use; the last third runs back to back.
	task automatic test_random_mix(input int n_items);
		int done;
		int r;
		int mode;
		logic [CMD_W-1:0] c;
		logic [POS_W-1:0] p;
		done = 0;
		while (done < n_items) begin
			if (done >= (n_items * 2) / 3)
				gaps_on = 1'b0;
			mode = (done / 40) % 3;
			r = $urandom_range(0, 99);
			if (r < (mode == 0 ? 55 : mode == 1 ? 20 : 35))
				c = CMD_ADD;
			else if (r < (mode == 0 ? 68 : mode == 1 ? 60 : 55))
				c = CMD_DEL;
			else if (r < (mode == 0 ? 78 : mode == 1 ? 72 : 70))
				c = CMD_FIND;
			else if (r < (mode == 0 ? 87 : mode == 1 ? 84 : 82))
				c = CMD_COUNT;
			else if (r < 96)
				c = CMD_LIST;
			else
				c = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
			r = $urandom_range(0, 99);
			if (r < 70 || shadow_len == 0)
				p = POS_W'(shadow_len);
			else if (r < 90)
				p = POS_W'($urandom_range(0, shadow_len - 1));
			else
				p = POS_W'($urandom_range(0, 63));
			if (r >= 70 && r < 72)
				p = POS_W'($urandom_range(0, 63));
			send_command(c, p, pick_value());
			if (c <= CMD_LIST)
				done++;
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		cmd           = CMD_ADD;
		position      = '0;
		value         = '0;
		gaps_on       = 1'b1;
		error_count   = 0;
		result_count  = 0;
		idle_cycles   = 0;
		ignored_count = 0;
		max_len_seen  = 0;
		full_hits     = 0;
		shadow_len    = 0;
		foreach (op_count[i])
			op_count[i] = 0;
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_table();
		test_add_and_overwrite();
		test_search();
		test_delete();
		test_list_and_unused();
		test_fill_and_drain();
		test_random_mix(265);

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never arrived", 64'(pending_results.size()), '0);

		$display("Covered %0d add, %0d delete, %0d find, %0d count, %0d list, %0d ignored",
		         op_count[CMD_ADD], op_count[CMD_DEL], op_count[CMD_FIND],
		         op_count[CMD_COUNT], op_count[CMD_LIST], ignored_count);
		$display("Checked %0d results; table peaked at %0d of %0d entries, full %0d times",
		         result_count, max_len_seen, DEPTH, full_hits);
		if (error_count == 0)
			$display("tb_ordered_list_table_unit: PASS");
		else
			$display("tb_ordered_list_table_unit: FAIL");
		$finish;
	end

endmodule
